// ===== design/lra_pkg.sv =====
// ----------------------------------------------------------------------------
// lra_pkg: shared types and tables for the LED ring animator
// Holds the command format passed from the front end to the back end, the
// request and register codes, and the brightness and switch decode tables.
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam int RING_LEDS_DEFAULT = 12;
  localparam int RING_OUT_W        = 12;
  localparam int QUEUE_DEPTH       = 2;
  localparam int SWEEP_LEN         = 28;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic REQ_SLOT = 1'b0;
  localparam logic REQ_ANIM = 1'b1;

  localparam logic MODE_CHASER = 1'b0;
  localparam logic MODE_SWEEP  = 1'b1;

  localparam logic [1:0] SPEED_SLOW = 2'd0;
  localparam logic [1:0] SPEED_MID  = 2'd1;
  localparam logic [1:0] SPEED_FAST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SLOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FAST = 2'd2;

  localparam logic [15:0] SPEED_SLOW_RESET = 16'd13107;
  localparam logic [15:0] SPEED_MID_RESET  = 16'd32768;
  localparam logic [15:0] SPEED_FAST_RESET = 16'd42598;

  localparam logic [7:0] CENTER_CHASE_LEVEL = 8'hF0;
  localparam logic [7:0] SLOT_MASK_RESET    = 8'h01;

  typedef logic [7:0] level_t;
  typedef level_t [2:0] level_set_t;

  // One classified tick on its way to the back end
  typedef struct packed {
    logic       anim;
    logic [1:0] speed;
    logic [1:0] bset;
    logic       mode;
  } cmd_t;

  // Switch code to {brightness set, speed code}
  function automatic logic [3:0] switch_decode(input logic [2:0] code);
    logic [3:0] r;
    unique case (code)
      3'd0: r = 4'h0;
      3'd1: r = 4'h8;
      3'd2: r = 4'h1;
      3'd3: r = 4'h5;
      3'd4: r = 4'h9;
      3'd5: r = 4'h2;
      3'd6: r = 4'h6;
      3'd7: r = 4'hA;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // Lead, middle and tail levels; set three reads as set two
  function automatic level_set_t level_set(input logic [1:0] bset);
    level_set_t r;
    unique case (bset)
      2'd0: r = {8'h19, 8'h80, 8'hFF};
      2'd1: r = {8'h33, 8'h99, 8'hFF};
      2'd2: r = {8'h4D, 8'hB3, 8'hFF};
      2'd3: r = {8'h4D, 8'hB3, 8'hFF};
      default: r = {8'h4D, 8'hB3, 8'hFF};
    endcase
    return r;
  endfunction

  // Fade ramp: 51 times k
  function automatic level_t ramp_level(input logic [2:0] k);
    level_t r;
    unique case (k)
      3'd0: r = 8'd0;
      3'd1: r = 8'd51;
      3'd2: r = 8'd102;
      3'd3: r = 8'd153;
      3'd4: r = 8'd204;
      3'd5: r = 8'd255;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/lra_front.sv =====
// ----------------------------------------------------------------------------
// lra_front: tick intake and classification
// Accepts ticks, decodes the switches into speed and brightness codes and
// pushes one command into the queue per transfer.
// ----------------------------------------------------------------------------
module lra_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           req_type,
  input  logic [2:0]     switch_code,
  input  logic           mode_switch,
  input  logic           q_full,
  output logic           q_push,
  output lra_pkg::cmd_t  q_cmd
);

  logic [3:0] dec;

  assign dec      = lra_pkg::switch_decode(switch_code);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.anim  = (req_type == lra_pkg::REQ_ANIM);
    q_cmd.speed = dec[1:0];
    q_cmd.bset  = dec[3:2];
    q_cmd.mode  = mode_switch;
  end

endmodule

// ===== design/lra_queue.sv =====
// ----------------------------------------------------------------------------
// lra_queue: command queue between front and back end
// Small flop-based FIFO of classified ticks.
// ----------------------------------------------------------------------------
module lra_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lra_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lra_pkg::cmd_t  head
);

  localparam int DEPTH = lra_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  lra_pkg::cmd_t         entry [DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/lra_back.sv =====
// ----------------------------------------------------------------------------
// lra_back: pattern engine and result register
// Holds LED, slot and animation state, carries out one command per cycle
// while its result register is free or read, and holds each result until taken.
// ----------------------------------------------------------------------------
module lra_back #(
  parameter int RING_LEDS = lra_pkg::RING_LEDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               q_valid,
  input  lra_pkg::cmd_t                      q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lra_pkg::RING_OUT_W-1:0]     ring_leds,
  output logic                               center_led,
  output logic [7:0]                         slot_reload,
  output logic [15:0]                        step_reload
);

  localparam int IW    = $clog2(RING_LEDS);
  localparam int OW    = lra_pkg::RING_OUT_W;
  localparam int SHOWN = (RING_LEDS < OW) ? RING_LEDS : OW;
  localparam int B11   = 2 - (11 % RING_LEDS);
  localparam int B12   = 2 - (12 % RING_LEDS);

  logic [15:0]          speed_slow;
  logic [15:0]          speed_mid;
  logic [15:0]          speed_fast;
  logic [RING_LEDS-1:0] ring_pins;
  logic [RING_LEDS-1:0] ring_pins_next;
  logic                 center_pin;
  logic                 center_pin_next;
  logic [7:0]           slot_mask;
  logic [4:0]           step_counter;
  logic [4:0]           step_counter_next;
  logic                 pattern_mode;
  logic [1:0]           brightness_set;
  logic [15:0]          step_sel;
  logic [OW-1:0]        ring_show;

  lra_pkg::level_set_t  lv;

  function automatic logic lit(input lra_pkg::level_t level, input logic [7:0] mask);
    return |(level & mask);
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign lv    = lra_pkg::level_set(brightness_set);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_slow <= lra_pkg::SPEED_SLOW_RESET;
      speed_mid  <= lra_pkg::SPEED_MID_RESET;
      speed_fast <= lra_pkg::SPEED_FAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lra_pkg::CFG_SPEED_SLOW: speed_slow <= cfg_data;
        lra_pkg::CFG_SPEED_MID:  speed_mid  <= cfg_data;
        lra_pkg::CFG_SPEED_FAST: speed_fast <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (q_head.speed)
      lra_pkg::SPEED_SLOW: step_sel = speed_slow;
      lra_pkg::SPEED_MID:  step_sel = speed_mid;
      default:             step_sel = speed_fast;
    endcase
  end

  // Pattern step for a slot tick; counter advance and ring clear for an animation tick
  always_comb begin
    logic [5:0] idx;
    logic [4:0] inc;
    logic [5:0] len;
    ring_pins_next    = ring_pins;
    center_pin_next   = center_pin;
    step_counter_next = step_counter;
    idx = '0;
    inc = step_counter + 5'd1;
    len = (q_head.mode == lra_pkg::MODE_SWEEP) ? 6'(lra_pkg::SWEEP_LEN) : 6'(RING_LEDS);
    if (q_head.anim) begin
      ring_pins_next    = '0;
      step_counter_next = ({1'b0, inc} >= len) ? 5'd0 : inc;
    end else if (pattern_mode == lra_pkg::MODE_CHASER) begin
      for (int i = 0; i < 3; i++) begin
        idx = {1'b0, step_counter} + 6'd3 - 6'(i);
        if (idx >= 6'(RING_LEDS)) begin
          idx = idx - 6'(RING_LEDS);
        end
        ring_pins_next[idx[IW-1:0]] = lit(lv[i], slot_mask);
      end
      center_pin_next = lit(lra_pkg::CENTER_CHASE_LEVEL, slot_mask);
    end else begin
      if (step_counter < 5'd3) begin
        for (int i = 0; i < 3; i++) begin
          if (5'(i) <= step_counter) begin
            ring_pins_next[IW'(i)] = lit(lv[2-i], slot_mask);
          end
        end
      end else if (step_counter < 5'd11) begin
        for (int i = 0; i < 3; i++) begin
          idx = {1'b0, step_counter} - 6'(i);
          if (idx < 6'(RING_LEDS)) begin
            ring_pins_next[idx[IW-1:0]] = lit(lv[i], slot_mask);
          end
        end
      end else if (step_counter == 5'd11) begin
        for (int k = 0; k < 2; k++) begin
          idx = 6'(9 + k);
          if (k < B11 && idx < 6'(RING_LEDS)) begin
            ring_pins_next[idx[IW-1:0]] = lit(lv[2-k], slot_mask);
          end
        end
      end else if (step_counter == 5'd12) begin
        for (int k = 0; k < 2; k++) begin
          idx = 6'(10 + k);
          if (k < B12 && idx < 6'(RING_LEDS)) begin
            ring_pins_next[idx[IW-1:0]] = lit(lv[2-k], slot_mask);
          end
        end
      end else if (step_counter < 5'd18) begin
        center_pin_next = lit(lra_pkg::ramp_level(3'(step_counter - 5'd12)), slot_mask);
      end else if (step_counter < 5'd23) begin
        ring_pins_next = {RING_LEDS{lit(lra_pkg::ramp_level(3'(step_counter - 5'd17)),
                                        slot_mask)}};
      end else if (step_counter < 5'(lra_pkg::SWEEP_LEN)) begin
        ring_pins_next  = {RING_LEDS{lit(lra_pkg::ramp_level(3'(5'd27 - step_counter)),
                                         slot_mask)}};
        center_pin_next = lit(lra_pkg::ramp_level(3'(5'd27 - step_counter)), slot_mask);
      end
    end
  end

  // Show only the low output-width LEDs; zero-fill a smaller ring
  always_comb begin
    ring_show = '0;
    for (int j = 0; j < SHOWN; j++) begin
      ring_show[j] = ring_pins_next[j];
    end
  end

  // Animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pins      <= '0;
      center_pin     <= 1'b0;
      slot_mask      <= lra_pkg::SLOT_MASK_RESET;
      step_counter   <= '0;
      pattern_mode   <= lra_pkg::MODE_CHASER;
      brightness_set <= '0;
    end else if (q_pop) begin
      ring_pins    <= ring_pins_next;
      center_pin   <= center_pin_next;
      step_counter <= step_counter_next;
      if (q_head.anim) begin
        pattern_mode   <= q_head.mode;
        brightness_set <= q_head.bset;
      end else begin
        slot_mask <= {slot_mask[0], slot_mask[7:1]};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ring_leds   <= ring_show;
      center_led  <= center_pin_next;
      slot_reload <= q_head.anim ? 8'd0 : ~slot_mask;
      step_reload <= q_head.anim ? step_sel : 16'd0;
    end
  end

endmodule

// ===== design/led_ring_animator_bcm.sv =====
// ----------------------------------------------------------------------------
// led_ring_animator_bcm: LED ring animator with binary-code modulation
// A transferred tick is written into the command queue, then applied by the
// pattern engine into the result register: one tick per cycle while results
// are taken. The two-entry command queue absorbs a stalled output for two
// ticks. Reset (sync, active high) clears LEDs, counter, mode and brightness
// set, loads the slot mask with one and restores the speed reload registers.
// ----------------------------------------------------------------------------
module led_ring_animator_bcm #(
  parameter int RING_LEDS = lra_pkg::RING_LEDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [2:0]                         switch_code,
  input  logic                               mode_switch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lra_pkg::RING_OUT_W-1:0]     ring_leds,
  output logic                               center_led,
  output logic [7:0]                         slot_reload,
  output logic [15:0]                        step_reload
);

  // Front end to queue
  logic          q_full;
  logic          q_push;
  lra_pkg::cmd_t q_cmd;

  // Queue to back end
  logic          q_valid;
  logic          q_pop;
  lra_pkg::cmd_t q_head;

  // Classify each transfer and push it as a command
  lra_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .switch_code (switch_code),
    .mode_switch (mode_switch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // Hold commands while the back end waits on the consumer
  lra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Apply pattern steps, advance the animation and register the result
  lra_back #(
    .RING_LEDS (RING_LEDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ring_leds   (ring_leds),
    .center_led  (center_led),
    .slot_reload (slot_reload),
    .step_reload (step_reload)
  );

endmodule

// ===== bench/led_ring_animator_bcm_tb.sv =====
// ----------------------------------------------------------------------------
// led_ring_animator_bcm_tb: self-checking bench for the LED ring animator
// Streams slot and animation ticks through the valid/ready ports with random
// gaps on both sides. An in-bench predictor tracks the LEDs, slot mask, step
// counter, mode and brightness set, and every frame is checked field by field
// in order across several speed reload settings, zero and all-ones included.
// ----------------------------------------------------------------------------
module led_ring_animator_bcm_tb;
  import lra_pkg::*;

  localparam int RING        = RING_LEDS_DEFAULT;
  localparam int SWEEP_STEPS = 28;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 300;
  localparam int NUM_PHASES  = 5;
  localparam int MAX_PRINTS  = 40;
  localparam int TAIL_CYCLES = 12;

  // Index past the last speed register; the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] CHASE_CENTER = 8'hF0;

  typedef struct packed {
    logic       req;
    logic [2:0] sw;
    logic       md;
  } tick_t;

  typedef struct packed {
    logic [RING_OUT_W-1:0] ring;
    logic                  center;
    logic [7:0]            slot;
    logic [15:0]           step;
  } frame_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_SLOT;
  logic [2:0]            switch_code = 3'd0;
  logic                  mode_switch = MODE_CHASER;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RING_OUT_W-1:0] ring_leds;
  logic                  center_led;
  logic [7:0]            slot_reload;
  logic [15:0]           step_reload;

  // Predicted block state
  logic [RING-1:0] ring_pins = '0;
  logic            center_pin = 1'b0;
  logic [7:0]      slot_mask = 8'h01;
  logic [4:0]      step_cnt = 5'd0;
  logic            pat_mode = MODE_CHASER;
  logic [1:0]      bright_set = 2'd0;
  logic [15:0]     reload_slow = 16'd13107;
  logic [15:0]     reload_mid = 16'd32768;
  logic [15:0]     reload_fast = 16'd42598;

  tick_t  tick_q[$];
  frame_t frame_q[$];
  tick_t  cur_tick;
  tick_t  next_tick;
  frame_t want;

  bit tick_taken = 1'b0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int frames_seen = 0;
  int ticks_queued = 0;
  int ticks_taken = 0;
  int slot_ticks = 0;
  int anim_ticks = 0;
  int sweep_ticks = 0;
  int settings = 1;

  led_ring_animator_bcm uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .switch_code(switch_code),
    .mode_switch(mode_switch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ring_leds  (ring_leds),
    .center_led (center_led),
    .slot_reload(slot_reload),
    .step_reload(step_reload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // An LED is on when its level has the bit picked by the current slot
  function automatic bit pin_on(input logic [7:0] level);
    return (level & slot_mask) != 8'd0;
  endfunction

  // Drop indexes that fall outside the ring
  function automatic void drive_ring(input int idx, input logic [7:0] level);
    if (idx >= 0 && idx < RING) begin
      ring_pins[idx] = pin_on(level);
    end
  endfunction

  // Position 0 is the lead of a chase group, 1 the middle, 2 the tail
  function automatic logic [7:0] group_level(input logic [1:0] bset, input int pos);
    logic [7:0] lv;
    lv = 8'hFF;
    if (pos == 1) begin
      case (bset)
        2'd0: lv = 8'h80;
        2'd1: lv = 8'h99;
        default: lv = 8'hB3;
      endcase
    end else if (pos == 2) begin
      case (bset)
        2'd0: lv = 8'h19;
        2'd1: lv = 8'h33;
        default: lv = 8'h4D;
      endcase
    end
    return lv;
  endfunction

  function automatic logic [1:0] speed_of(input logic [2:0] sw);
    case (sw)
      3'd0, 3'd1:       return SPEED_SLOW;
      3'd2, 3'd3, 3'd4: return SPEED_MID;
      default:          return SPEED_FAST;
    endcase
  endfunction

  function automatic logic [1:0] bset_of(input logic [2:0] sw);
    case (sw)
      3'd0, 3'd2, 3'd5: return 2'd0;
      3'd3, 3'd6:       return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  // Advance the predicted state by one tick and return the frame it shows
  function automatic frame_t animate_tick(input tick_t t);
    frame_t     f;
    int         c;
    int         i;
    int         k;
    int         bound;
    int         len;
    logic [7:0] fade;
    f = '0;
    c = int'(step_cnt);
    if (t.req == REQ_SLOT) begin
      if (pat_mode == MODE_CHASER) begin
        for (i = 0; i < 3; i++) begin
          drive_ring((c + 3 - i) % RING, group_level(bright_set, i));
        end
        center_pin = pin_on(CHASE_CENTER);
      end else if (c < 3) begin
        // sweep enters from LED 0, tail first
        for (i = 0; i <= c; i++) begin
          drive_ring(i, group_level(bright_set, 2 - i));
        end
      end else if (c < 11) begin
        for (i = 0; i < 3; i++) begin
          drive_ring(c - i, group_level(bright_set, i));
        end
      end else if (c < 13) begin
        // step eleven touches nothing; step twelve redraws the last two LEDs
        bound = 2 - (c % RING);
        for (k = 0; k < bound; k++) begin
          drive_ring(c + k - 2, group_level(bright_set, 2 - k));
        end
      end else if (c < 18) begin
        fade = 8'(51 * (c - 12));
        center_pin = pin_on(fade);
      end else if (c < 23) begin
        fade = 8'(51 * (c - 17));
        for (i = 0; i < RING; i++) begin
          drive_ring(i, fade);
        end
      end else if (c < SWEEP_STEPS) begin
        fade = 8'(255 - 51 * (c - 22));
        for (i = 0; i < RING; i++) begin
          drive_ring(i, fade);
        end
        center_pin = pin_on(fade);
      end
      f.slot = ~slot_mask;
      slot_mask = {slot_mask[0], slot_mask[7:1]};
    end else begin
      case (speed_of(t.sw))
        SPEED_SLOW: f.step = reload_slow;
        SPEED_MID:  f.step = reload_mid;
        default:    f.step = reload_fast;
      endcase
      bright_set = bset_of(t.sw);
      pat_mode = t.md;
      len = (pat_mode == MODE_CHASER) ? RING : SWEEP_STEPS;
      step_cnt = step_cnt + 5'd1;
      // counter overrun: wrap as soon as the new mode's length is reached
      if (int'(step_cnt) >= len) begin
        step_cnt = 5'd0;
      end
      ring_pins = '0;
    end
    f.ring = ring_pins[RING_OUT_W-1:0];
    f.center = center_pin;
    return f;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("MISMATCH frame %0d %s: got 0x%0h, expected 0x%0h", frames_seen, what, got,
               exp_v);
    end
  endtask

  task automatic push_tick(input logic req, input logic [2:0] sw, input logic md);
    tick_t t;
    t.req = req;
    t.sw = sw;
    t.md = md;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  // Write one register and mirror it into the predictor; the block is idle here
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SPEED_SLOW: reload_slow = val;
      CFG_SPEED_MID:  reload_mid = val;
      CFG_SPEED_FAST: reload_fast = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued tick is transferred and every frame is back
  task automatic wait_idle();
    while (ticks_taken != ticks_queued || frame_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Check outputs first so a stray frame can never pair with a tick taken
  // at the same edge, then predict the frame for any tick just transferred.
  always @(posedge clk) begin
    tick_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          report("frame with nothing expected, ring", 32'(ring_leds), 32'd0);
        end else begin
          want = frame_q.pop_front();
          if (ring_leds !== want.ring)
            report("ring_leds", 32'(ring_leds), 32'(want.ring));
          if (center_led !== want.center)
            report("center_led", 32'(center_led), 32'(want.center));
          if (slot_reload !== want.slot)
            report("slot_reload", 32'(slot_reload), 32'(want.slot));
          if (step_reload !== want.step)
            report("step_reload", 32'(step_reload), 32'(want.step));
        end
        frames_seen++;
      end
      if (in_valid && in_ready) begin
        tick_taken = 1'b1;
        cur_tick = {req_type, switch_code, mode_switch};
        if (cur_tick.req == REQ_SLOT) begin
          slot_ticks++;
          if (pat_mode == MODE_SWEEP) sweep_ticks++;
        end else begin
          anim_ticks++;
        end
        frame_q.push_back(animate_tick(cur_tick));
        ticks_taken++;
      end
    end
  end

  // Tick driver: hold the payload until transfer, then idle for the gap
  // picked at launch. Scramble the payload during that gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !tick_taken) begin
      // hold
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
      req_type <= 1'($urandom_range(0, 1));
      switch_code <= 3'($urandom_range(0, 7));
      mode_switch <= 1'($urandom_range(0, 1));
    end else if (tick_q.size() != 0) begin
      next_tick = tick_q.pop_front();
      req_type <= next_tick.req;
      switch_code <= next_tick.sw;
      mode_switch <= next_tick.md;
      in_valid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Frame receiver: stall out_ready at random, independent of out_valid
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  // Run clock: switch whole stretches to no idling now and then, and end
  // the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles % 200 == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames outstanding", cycles, frame_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int       ph;
    int       target;
    int       steps;
    int       s;
    int       b;
    int       burst;
    logic     md;
    logic [2:0] sw;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset reload values: every switch code, both
    // modes, the silent step eleven, the step twelve wrap, and a counter
    // overrun when the sweep hands over to the chaser past its length.
    push_tick(REQ_SLOT, 3'd0, MODE_CHASER);
    push_tick(REQ_ANIM, 3'd0, MODE_CHASER);
    push_tick(REQ_SLOT, 3'd0, MODE_CHASER);
    push_tick(REQ_ANIM, 3'd1, MODE_CHASER);
    push_tick(REQ_SLOT, 3'd7, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd2, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd0, MODE_CHASER);
    push_tick(REQ_ANIM, 3'd3, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd5, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd4, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd5, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd6, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd7, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd2, MODE_CHASER);
    push_tick(REQ_ANIM, 3'd7, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd7, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd7, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd0, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd7, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd0, MODE_SWEEP);
    push_tick(REQ_SLOT, 3'd0, MODE_SWEEP);
    push_tick(REQ_ANIM, 3'd0, MODE_CHASER);
    push_tick(REQ_SLOT, 3'd0, MODE_CHASER);
    push_tick(REQ_SLOT, 3'd0, MODE_CHASER);
    wait_idle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Reprogram the speed reloads between phases, extremes first
      case (ph)
        0: begin
          write_reg(CFG_SPEED_SLOW, 16'h0000);
          write_reg(CFG_SPEED_MID, 16'h0000);
          write_reg(CFG_SPEED_FAST, 16'h0000);
        end
        1: begin
          write_reg(CFG_SPEED_SLOW, 16'hFFFF);
          write_reg(CFG_SPEED_MID, 16'hFFFF);
          write_reg(CFG_SPEED_FAST, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_SPEED_SLOW, 16'h0000);
          write_reg(CFG_SPEED_MID, 16'hFFFF);
          write_reg(CFG_SPEED_FAST, 16'hAAAA);
          write_reg(CFG_UNUSED, 16'h5555);
        end
        default: begin
          write_reg(CFG_SPEED_SLOW, 16'($urandom_range(0, 65535)));
          write_reg(CFG_SPEED_MID, 16'($urandom_range(0, 65535)));
          write_reg(CFG_SPEED_FAST, 16'($urandom_range(0, 65535)));
          write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        end
      endcase
      settings++;

      target = ticks_queued + PHASE_TICKS;
      while (ticks_queued < target) begin
        if ($urandom_range(0, 99) < 80) begin
          // One animation run in a fixed mode of eight to forty steps, with a burst
          // of slot ticks after each step so the slot mask visits every brightness
          // bit.
          md = 1'($urandom_range(0, 1));
          sw = 3'($urandom_range(0, 7));
          steps = $urandom_range(8, 40);
          for (s = 0; s < steps; s++) begin
            if ($urandom_range(0, 9) == 0) sw = 3'($urandom_range(0, 7));
            push_tick(REQ_ANIM, sw, md);
            burst = $urandom_range(0, 6);
            for (b = 0; b < burst; b++) begin
              push_tick(REQ_SLOT, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
          end
        end else begin
          // Noise: fully random ticks, mode flips included
          burst = $urandom_range(1, 10);
          for (b = 0; b < burst; b++) begin
            push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
          end
        end
      end
      wait_idle();
    end

    // Catch any stray frame the block might still emit
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d slot ticks (%0d in sweep mode) and %0d animation ticks",
             slot_ticks, sweep_ticks, anim_ticks);
    $display("Checked %0d frames under %0d speed reload settings, %0d mismatches",
             frames_seen, settings, errors);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lra_pkg.sv
design/lra_front.sv
design/lra_queue.sv
design/lra_back.sv
design/led_ring_animator_bcm.sv
bench/led_ring_animator_bcm_tb.sv
